// ----- sv/uhpc_pkg.sv -----
// ---------------------------------------------------------------------------
// uhpc_pkg
// Shared constants, character codes and record types of the URL host/port
// classifier.
// ---------------------------------------------------------------------------
package uhpc_pkg;

    // Default host buffer size and queue depth
    localparam int HostBufferBytesDef = 64;
    localparam int QueueDepth         = 2;

    // Configuration register indexes and reset values
    localparam int            CfgIndexWidth  = 2;
    localparam logic [1:0]    CfgNetPrefix   = 2'd0;
    localparam logic [1:0]    CfgNetMask     = 2'd1;
    localparam logic [31:0]   NetPrefixReset = 32'h6440_0000;
    localparam logic [31:0]   NetMaskReset   = 32'hFFC0_0000;

    // Characters
    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpZ   = 8'h5A;
    localparam logic [7:0] CaseBit = 8'h20;

    // Lower-case ".ts.net" packed as seven bytes, first byte highest
    localparam logic [55:0] SuffixPacked = 56'h2E74732E6E6574;
    localparam logic [3:0]  SuffixLen    = 4'd7;
    localparam logic [3:0]  TextLenMax   = 4'd8;

    // Scheme "https"
    localparam logic [2:0] SchemeLen = 3'd5;

    // Number limits
    localparam logic [8:0]  OctetMax = 9'd255;
    localparam logic [8:0]  OctetSat = 9'd256;
    localparam logic [16:0] PortMax  = 17'd65535;
    localparam logic [16:0] PortSat  = 17'd65536;
    localparam logic [15:0] PortHttps = 16'd443;
    localparam logic [15:0] PortHttp  = 16'd80;

    // Expected scheme character at a given match position
    function automatic logic [7:0] scheme_char_at(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h68; // h
            3'd1:    c = 8'h74; // t
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h70; // p
            3'd4:    c = 8'h73; // s
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Summary of one parsed URL, front to back
    typedef struct packed {
        logic        host_ok;     // separator seen, host length in range
        logic        quad_ok;     // strict dotted quad parsed
        logic [31:0] quad;
        logic        suffix;      // host ends in .ts.net
        logic        explicit;    // port given after ':'
        logic        port_good;   // explicit port digits in 1..65535
        logic [15:0] port;
        logic        https;
        logic [5:0]  host_len;
    } uhpc_rec_t;

    // One result item
    typedef struct packed {
        logic        peer_valid;
        logic [31:0] peer_address;
        logic [15:0] peer_port;
        logic        name_suffix_hit;
        logic [5:0]  host_length;
    } uhpc_res_t;

endpackage

// ----- sv/uhpc_fifo.sv -----
// ---------------------------------------------------------------------------
// uhpc_fifo
// Small register FIFO with first-word fall-through; used between the parser
// and the evaluator and as the result queue.
// ---------------------------------------------------------------------------
module uhpc_fifo
    import uhpc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QueueDepth
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- sv/uhpc_front.sv -----
// ---------------------------------------------------------------------------
// uhpc_front
// Byte-serial URL parser: scheme, "://" separator, host (dotted quad and
// name suffix), explicit port. Emits one summary record per URL.
// ---------------------------------------------------------------------------
module uhpc_front
    import uhpc_pkg::*;
#(
    parameter int HOST_BUFFER_BYTES = HostBufferBytesDef
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_accept,
    input  logic [7:0] url_byte,
    input  logic      last_byte,
    output logic      rec_push,
    output uhpc_rec_t rec
);

    localparam int HCW = $clog2(HOST_BUFFER_BYTES + 1);
    localparam int HXW = (HCW > 6) ? HCW : 6;

    typedef enum logic [1:0] {PH_SCHEME, PH_HOST, PH_PORT, PH_PATH} phase_t;

    phase_t         phase_reg,    phase_next;
    logic [2:0]     scnt_reg,     scnt_next;
    logic           smis_reg,     smis_next;
    logic [1:0]     sep_reg,      sep_next;
    logic [HCW-1:0] hcnt_reg,     hcnt_next;
    logic [55:0]    window_reg,   window_next;
    logic [8:0]     oct_reg,      oct_next;
    logic [1:0]     oidx_reg,     oidx_next;
    logic [23:0]    acc_reg,      acc_next;
    logic           qok_reg,      qok_next;
    logic [16:0]    pval_reg,     pval_next;
    logic           pexp_reg,     pexp_next;
    logic           pdig_reg,     pdig_next;
    logic           pbad_reg,     pbad_next;
    logic           cut_reg,      cut_next;
    logic [3:0]     tlen_reg,     tlen_next;
    logic           odig_reg,     odig_next;

    logic           is_digit;
    logic [3:0]     digit;
    logic [7:0]     lc;
    logic [11:0]    oct_mul;
    logic [19:0]    port_mul;
    logic [HXW-1:0] hcnt_ext;

    assign is_digit = (url_byte >= ChZero) && (url_byte <= ChNine);
    assign digit    = 4'(url_byte - ChZero);
    assign lc       = ((url_byte >= ChUpA) && (url_byte <= ChUpZ)) ? (url_byte | CaseBit)
                                                                     : url_byte;
    assign oct_mul  = 12'({3'b0, oct_reg} * 12'd10) + {8'b0, digit};
    assign port_mul = 20'({3'b0, pval_reg} * 20'd10) + {16'b0, digit};

    // Next-state for the accepted byte
    always_comb
    begin
        phase_next  = phase_reg;
        scnt_next   = scnt_reg;
        smis_next   = smis_reg;
        sep_next    = sep_reg;
        hcnt_next   = hcnt_reg;
        window_next = window_reg;
        oct_next    = oct_reg;
        oidx_next   = oidx_reg;
        acc_next    = acc_reg;
        qok_next    = qok_reg;
        pval_next   = pval_reg;
        pexp_next   = pexp_reg;
        pdig_next   = pdig_reg;
        pbad_next   = pbad_reg;
        cut_next    = cut_reg;
        tlen_next   = tlen_reg;
        odig_next   = odig_reg;

        case (phase_reg)
            PH_SCHEME:
            begin
                if (sep_reg != 2'd0 && url_byte == ChSlash)
                begin
                    if (sep_reg == 2'd2)
                    begin
                        phase_next = PH_HOST;
                        sep_next   = 2'd0;
                    end
                    else
                    begin
                        sep_next = 2'd2;
                    end
                end
                else
                begin
                    // broken partial separator counts as scheme text
                    if (sep_reg != 2'd0)
                    begin
                        smis_next = 1'b1;
                    end
                    if (url_byte == ChColon)
                    begin
                        sep_next = 2'd1;
                    end
                    else
                    begin
                        sep_next = 2'd0;
                        if (scnt_reg < SchemeLen && url_byte == scheme_char_at(scnt_reg))
                        begin
                            scnt_next = scnt_reg + 1'b1;
                        end
                        else
                        begin
                            smis_next = 1'b1;
                        end
                    end
                end
            end
            PH_HOST:
            begin
                if (url_byte == ChColon)
                begin
                    phase_next = PH_PORT;
                    pexp_next  = 1'b1;
                end
                else if (url_byte == ChSlash)
                begin
                    phase_next = PH_PATH;
                end
                else
                begin
                    if (hcnt_reg < HCW'(HOST_BUFFER_BYTES))
                    begin
                        hcnt_next = hcnt_reg + 1'b1;
                    end
                    if (url_byte == ChNul)
                    begin
                        cut_next = 1'b1;
                    end
                    // host text stops at a zero byte
                    if (!(cut_reg || url_byte == ChNul))
                    begin
                        if (tlen_reg < TextLenMax)
                        begin
                            tlen_next = tlen_reg + 1'b1;
                        end
                        window_next = {window_reg[47:0], lc};
                        if (is_digit)
                        begin
                            oct_next  = (oct_mul > 12'(OctetSat)) ? OctetSat : oct_mul[8:0];
                            odig_next = 1'b1;
                        end
                        else if (url_byte == ChDot)
                        begin
                            if (!odig_reg || oidx_reg == 2'd3 || oct_reg > OctetMax)
                            begin
                                qok_next = 1'b0;
                            end
                            else
                            begin
                                acc_next  = {acc_reg[15:0], oct_reg[7:0]};
                                oidx_next = oidx_reg + 1'b1;
                            end
                            oct_next  = '0;
                            odig_next = 1'b0;
                        end
                        else
                        begin
                            qok_next = 1'b0;
                        end
                    end
                end
            end
            PH_PORT:
            begin
                if (url_byte == ChSlash)
                begin
                    phase_next = PH_PATH;
                end
                else if (is_digit)
                begin
                    pval_next = (port_mul > 20'(PortSat)) ? PortSat : port_mul[16:0];
                    pdig_next = 1'b1;
                end
                else
                begin
                    pbad_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Summary record from the state after the last byte
    assign hcnt_ext = HXW'(hcnt_next);
    assign rec_push = in_accept && last_byte;

    always_comb
    begin
        rec.host_ok   = (phase_next != PH_SCHEME) && (hcnt_next != '0)
                        && (hcnt_next < HCW'(HOST_BUFFER_BYTES));
        rec.quad_ok   = qok_next && odig_next && (oidx_next == 2'd3) && (oct_next <= OctetMax);
        rec.quad      = {acc_next, oct_next[7:0]};
        rec.suffix    = (tlen_next > SuffixLen) && (window_next == SuffixPacked);
        rec.explicit  = pexp_next;
        rec.port_good = pdig_next && !pbad_next && (pval_next != '0) && (pval_next <= PortMax);
        rec.port      = pval_next[15:0];
        rec.https     = !smis_next && (scnt_next == SchemeLen);
        rec.host_len  = hcnt_ext[5:0];
    end

    // Parser state; cleared after each last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SCHEME;
            scnt_reg   <= '0;
            smis_reg   <= 1'b0;
            sep_reg    <= '0;
            hcnt_reg   <= '0;
            window_reg <= '0;
            oct_reg    <= '0;
            oidx_reg   <= '0;
            acc_reg    <= '0;
            qok_reg    <= 1'b1;
            pval_reg   <= '0;
            pexp_reg   <= 1'b0;
            pdig_reg   <= 1'b0;
            pbad_reg   <= 1'b0;
            cut_reg    <= 1'b0;
            tlen_reg   <= '0;
            odig_reg   <= 1'b0;
        end
        else if (in_accept)
        begin
            if (last_byte)
            begin
                phase_reg  <= PH_SCHEME;
                scnt_reg   <= '0;
                smis_reg   <= 1'b0;
                sep_reg    <= '0;
                hcnt_reg   <= '0;
                window_reg <= '0;
                oct_reg    <= '0;
                oidx_reg   <= '0;
                acc_reg    <= '0;
                qok_reg    <= 1'b1;
                pval_reg   <= '0;
                pexp_reg   <= 1'b0;
                pdig_reg   <= 1'b0;
                pbad_reg   <= 1'b0;
                cut_reg    <= 1'b0;
                tlen_reg   <= '0;
                odig_reg   <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                scnt_reg   <= scnt_next;
                smis_reg   <= smis_next;
                sep_reg    <= sep_next;
                hcnt_reg   <= hcnt_next;
                window_reg <= window_next;
                oct_reg    <= oct_next;
                oidx_reg   <= oidx_next;
                acc_reg    <= acc_next;
                qok_reg    <= qok_next;
                pval_reg   <= pval_next;
                pexp_reg   <= pexp_next;
                pdig_reg   <= pdig_next;
                pbad_reg   <= pbad_next;
                cut_reg    <= cut_next;
                tlen_reg   <= tlen_next;
                odig_reg   <= odig_next;
            end
        end
    end

endmodule

// ----- sv/uhpc_back.sv -----
// ---------------------------------------------------------------------------
// uhpc_back
// Holds the subnet registers and turns a parsed record into the final
// result: subnet match, name check, port selection.
// ---------------------------------------------------------------------------
module uhpc_back
    import uhpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [31:0]              cfg_data,
    input  uhpc_rec_t                rec,
    output uhpc_res_t                res
);

    logic [31:0] net_prefix_reg;
    logic [31:0] net_mask_reg;
    logic [31:0] ip;
    logic        hit;
    logic        valid;
    logic [15:0] port_sel;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_prefix_reg <= NetPrefixReset;
            net_mask_reg   <= NetMaskReset;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CfgNetPrefix)
            begin
                net_prefix_reg <= cfg_data;
            end
            else if (cfg_index == CfgNetMask)
            begin
                net_mask_reg <= cfg_data;
            end
        end
    end

    // Subnet match and port choice
    assign ip       = (rec.quad_ok && ((rec.quad & net_mask_reg) == net_prefix_reg))
                      ? rec.quad : '0;
    assign hit      = (ip != '0) || rec.suffix;
    assign port_sel = rec.explicit ? rec.port : (rec.https ? PortHttps : PortHttp);
    assign valid    = rec.host_ok && hit && (!rec.explicit || rec.port_good);

    // Invalid results carry all-zero fields
    always_comb
    begin
        res.peer_valid      = valid;
        res.peer_address    = valid ? ip : '0;
        res.peer_port       = valid ? port_sel : '0;
        res.name_suffix_hit = valid && rec.suffix;
        res.host_length     = valid ? rec.host_len : '0;
    end

endmodule

// ----- sv/url_host_port_classifier_core.sv -----
// ---------------------------------------------------------------------------
// url_host_port_classifier_core
// Streams a URL one byte at a time and reports whether it names an overlay
// peer, with its address, port, name-suffix flag and host length.
// ---------------------------------------------------------------------------
// Takes one URL byte per cycle while full is low, with no gaps needed; every
// byte flagged last yields exactly one result, valid or all-zero. The parser
// updates its state in the cycle a byte is accepted, drops a record into a
// two-entry queue on the last byte, and the evaluator (one 32-bit mask compare
// plus port select) moves it into a two-entry result queue when that queue has
// room; a result is registered in both queues before it shows on the output.
// full rises only when both queues are backed up by a stalled result consumer.
// Subnet registers are written through the cfg channel, which is always ready.
module url_host_port_classifier_core
    import uhpc_pkg::*;
#(
    parameter int HOST_BUFFER_BYTES = HostBufferBytesDef
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // input bytes
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               url_byte,
    input  logic                     last_byte,
    // results
    output logic                     empty,
    input  logic                     pop,
    output logic                     peer_valid,
    output logic [31:0]              peer_address,
    output logic [15:0]              peer_port,
    output logic                     name_suffix_hit,
    output logic [5:0]               host_length,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [31:0]              cfg_data
);

    logic      in_accept;
    logic      rec_push;
    uhpc_rec_t rec_in;
    uhpc_rec_t rec_head;
    logic      mid_empty;
    logic      res_full;
    logic      move;
    uhpc_res_t res_in;
    uhpc_res_t res_head;

    assign in_accept = push && !full;
    assign move      = !mid_empty && !res_full;

    // Parser
    uhpc_front #(
        .HOST_BUFFER_BYTES(HOST_BUFFER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .url_byte  (url_byte),
        .last_byte (last_byte),
        .rec_push  (rec_push),
        .rec       (rec_in)
    );

    // Record queue between parser and evaluator
    uhpc_fifo #(
        .WIDTH($bits(uhpc_rec_t)),
        .DEPTH(QueueDepth)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_push),
        .wdata (rec_in),
        .full  (full),
        .pop   (move),
        .rdata (rec_head),
        .empty (mid_empty)
    );

    // Evaluator and subnet registers
    uhpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec       (rec_head),
        .res       (res_in)
    );

    // Result queue
    uhpc_fifo #(
        .WIDTH($bits(uhpc_res_t)),
        .DEPTH(QueueDepth)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (move),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign peer_valid      = res_head.peer_valid;
    assign peer_address    = res_head.peer_address;
    assign peer_port       = res_head.peer_port;
    assign name_suffix_hit = res_head.name_suffix_hit;
    assign host_length     = res_head.host_length;

    // Records enter the queue only on an accepted last byte
    a_rec_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |-> (push && !full && last_byte))
        else $error("record pushed without accepted last byte");

    // Invalid results carry zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !peer_valid) |-> (peer_address == '0 && peer_port == '0
                                     && !name_suffix_hit && host_length == '0))
        else $error("invalid result with nonzero fields");

    // A valid peer has a port, a host length and either an address or the name suffix
    a_valid_port: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && peer_valid) |-> (peer_port != '0 && host_length != '0))
        else $error("valid result with zero port or host length");

    a_valid_host: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && peer_valid) |-> (peer_address != '0 || name_suffix_hit))
        else $error("valid result with neither address nor suffix");

endmodule
